// ----- sv/neighbour_mean_smoother_assert.svh -----
// Assertion macros for the neighbour mean smoother.
`ifndef NEIGHBOUR_MEAN_SMOOTHER_ASSERT_SVH
`define NEIGHBOUR_MEAN_SMOOTHER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define NMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nms_pkg.sv -----
// Shared constants and types of the neighbour mean smoother.
package nms_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int SAMPLE_BITS    = 8;
  localparam int IN_BITS        = 8;
  localparam int SMOOTH_BITS    = 16;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = 12;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = WIDTH_BITS'(5);
  localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = HEIGHT_BITS'(5);
  localparam int MIN_SIZE = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

  localparam int SUM_BITS    = SAMPLE_BITS + 3;
  localparam int FRAC_BITS   = 8;
  localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
  localparam int RECIP_SHIFT = DIV_BITS + 1;
  localparam int PROD_BITS   = DIV_BITS + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP3 = RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 3);
  localparam logic [RECIP_SHIFT-1:0] RECIP5 = RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 5);
  localparam logic [2:0] DIVISOR3   = 3'd3;
  localparam logic [2:0] DIVISOR5   = 3'd5;
  localparam int         DIV8_SHIFT = 3;

  localparam int MAX_RUN       = 4;
  localparam int FIFO_DEPTH    = 16;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CNT3,
    CNT5,
    CNT8
  } cnt_t;

  typedef logic [2:0][2:0][SAMPLE_BITS-1:0] win_t;

  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic row_last;
    logic col_ge1;
    logic col_ge2;
    logic col_last;
  } pos_flags_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    cnt_t                cnt;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
    logic                fend;
  } res_t;

endpackage

// ----- sv/neighbour_mean_smoother.sv -----
// Top level of the neighbour mean smoother: 3x3 mean of the neighbours, centre excluded.
// Data path: window stage, then a 16-entry result queue, then the output register.
// Throughput: one sample per cycle unless in_stall; the line memory is read on acceptance
// and written back the next cycle. Results leave one per cycle unless out_stall, so the
// up to four results at a row end stall input once the queue lacks room for another run.
// Reset: size 5 by 5, position row 0 column 0, window zero; the line memory is not cleared.
module neighbour_mean_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nms_pkg::IN_BITS-1:0]        in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [nms_pkg::SMOOTH_BITS-1:0]    out_smoothed,
  output logic [nms_pkg::ROW_BITS-1:0]       out_row,
  output logic [nms_pkg::COL_BITS-1:0]       out_col,
  output logic                               out_last_in_run,
  output logic                               out_frame_end,
  input  logic                               cfg_we,
  input  logic [nms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import nms_pkg::*;

  `include "neighbour_mean_smoother_assert.svh"

  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [COL_BITS-1:0]    col_r;
  logic [ROW_BITS-1:0]    row_r;
  logic                   in_take;
  logic                   col_last;
  logic                   row_last;
  logic [WIDTH_BITS-1:0]  cfg_width;
  logic [HEIGHT_BITS-1:0] cfg_height;

  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_BITS-1:0] rd_data_r;

  logic                   p1_valid_r;
  logic [SAMPLE_BITS-1:0] p1_sample_r;
  logic [COL_BITS-1:0]    p1_col_r;
  logic [ROW_BITS-1:0]    p1_row_r;
  pos_flags_t             p1_flags_r;

  win_t win_r;
  win_t win_nxt;

  res_t                     res [MAX_RUN];
  logic [MAX_RUN-1:0]       pres;
  logic [FIFO_PTR_BITS-1:0] wr_idx [MAX_RUN];
  logic [FIFO_PTR_BITS:0]   push_n;

  res_t                     fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r;
  logic [FIFO_PTR_BITS:0]   fifo_count_r;
  logic                     fifo_pop;
  res_t                     head;

  logic                   out_valid_r;
  logic [SMOOTH_BITS-1:0] out_smoothed_r;
  logic [ROW_BITS-1:0]    out_row_r;
  logic [COL_BITS-1:0]    out_col_r;
  logic                   out_last_in_run_r;
  logic                   out_frame_end_r;

  function automatic logic [SUM_BITS-1:0] neigh_sum(win_t w, logic [2:0] rm, logic [2:0] cm,
                                                    int rc, int cc);
    logic [SUM_BITS-1:0] s;
    s = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rm[r] && cm[c] && !(r == rc && c == cc)) begin
          s = s + SUM_BITS'(w[r][c]);
        end
      end
    end
    return s;
  endfunction

  function automatic cnt_t neigh_cnt(logic rm0, logic cm0);
    cnt_t n;
    if (rm0 && cm0) begin
      n = CNT8;
    end else if (rm0 || cm0) begin
      n = CNT5;
    end else begin
      n = CNT3;
    end
    return n;
  endfunction

  function automatic logic [SMOOTH_BITS-1:0] mean_q(logic [SUM_BITS-1:0] sum, cnt_t cnt);
    logic [DIV_BITS-1:0]    x;
    logic [DIV_BITS-1:0]    q;
    logic [DIV_BITS-1:0]    rem;
    logic [PROD_BITS-1:0]   prod;
    logic [RECIP_SHIFT-1:0] recip;
    logic [2:0]             d;
    x     = {sum, FRAC_BITS'(0)};
    recip = RECIP3;
    d     = DIVISOR3;
    q     = x >> DIV8_SHIFT;
    unique case (cnt)
      CNT3: begin
        recip = RECIP3;
        d     = DIVISOR3;
      end
      CNT5: begin
        recip = RECIP5;
        d     = DIVISOR5;
      end
      default: begin
        recip = '0;
        d     = '0;
      end
    endcase
    if (cnt == CNT3 || cnt == CNT5) begin
      prod = PROD_BITS'(x) * PROD_BITS'(recip);
      q    = DIV_BITS'(prod >> RECIP_SHIFT);
      rem  = x - q * DIV_BITS'(d);
      if (rem >= DIV_BITS'(d)) begin
        q = q + 1'b1;
      end
    end
    return q[SMOOTH_BITS-1:0];
  endfunction

  assign in_take    = in_valid && !in_stall;
  assign in_stall   = (int'(fifo_count_r) + (p1_valid_r ? MAX_RUN : 0)) >
                      (FIFO_DEPTH - MAX_RUN);
  assign col_last   = (WIDTH_BITS'(col_r) + 1'b1) == width_r;
  assign row_last   = (HEIGHT_BITS'(row_r) + 1'b1) == height_r;
  assign cfg_width  = cfg_data[WIDTH_BITS-1:0];
  assign cfg_height = cfg_data[HEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (int'(cfg_width) >= MIN_SIZE && int'(cfg_width) <= MAX_WIDTH) begin
            width_r <= cfg_width;
          end
          col_r <= '0;
          row_r <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          if (int'(cfg_height) >= MIN_SIZE && int'(cfg_height) <= MAX_HEIGHT) begin
            height_r <= cfg_height;
          end
          col_r <= '0;
          row_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_take) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_data_r <= line_mem[col_r];
    end
    if (p1_valid_r) begin
      line_mem[p1_col_r] <= {rd_data_r[SAMPLE_BITS-1:0], p1_sample_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_take;
    end
    if (in_take) begin
      p1_sample_r         <= in_sample[SAMPLE_BITS-1:0];
      p1_col_r            <= col_r;
      p1_row_r            <= row_r;
      p1_flags_r.row_ge1  <= row_r != '0;
      p1_flags_r.row_ge2  <= row_r > ROW_BITS'(1);
      p1_flags_r.row_last <= row_last;
      p1_flags_r.col_ge1  <= col_r != '0;
      p1_flags_r.col_ge2  <= col_r > COL_BITS'(1);
      p1_flags_r.col_last <= col_last;
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_data_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
    win_nxt[1][2] = rd_data_r[SAMPLE_BITS-1:0];
    win_nxt[2][2] = p1_sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (p1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    logic [2:0]             rm_up;
    logic [2:0]             cm_left;
    logic [FIFO_PTR_BITS:0] off;
    rm_up   = {2'b11, p1_flags_r.row_ge2};
    cm_left = {2'b11, p1_flags_r.col_ge2};

    res[0].sum = neigh_sum(win_nxt, rm_up, cm_left, 1, 1);
    res[0].cnt = neigh_cnt(p1_flags_r.row_ge2, p1_flags_r.col_ge2);
    res[0].row = p1_row_r - 1'b1;
    res[0].col = p1_col_r - 1'b1;

    res[1].sum = neigh_sum(win_nxt, rm_up, 3'b110, 1, 2);
    res[1].cnt = neigh_cnt(p1_flags_r.row_ge2, 1'b0);
    res[1].row = p1_row_r - 1'b1;
    res[1].col = p1_col_r;

    res[2].sum = neigh_sum(win_nxt, 3'b110, cm_left, 2, 1);
    res[2].cnt = neigh_cnt(1'b0, p1_flags_r.col_ge2);
    res[2].row = p1_row_r;
    res[2].col = p1_col_r - 1'b1;

    res[3].sum = neigh_sum(win_nxt, 3'b110, 3'b110, 2, 2);
    res[3].cnt = CNT3;
    res[3].row = p1_row_r;
    res[3].col = p1_col_r;

    pres[0] = p1_valid_r && p1_flags_r.row_ge1 && p1_flags_r.col_ge1;
    pres[1] = p1_valid_r && p1_flags_r.row_ge1 && p1_flags_r.col_last;
    pres[2] = p1_valid_r && p1_flags_r.row_last && p1_flags_r.col_ge1;
    pres[3] = p1_valid_r && p1_flags_r.row_last && p1_flags_r.col_last;

    res[0].fend = 1'b0;
    res[1].fend = 1'b0;
    res[2].fend = 1'b0;
    res[3].fend = 1'b1;

    off = '0;
    for (int k = 0; k < MAX_RUN; k++) begin
      wr_idx[k]   = wr_ptr_r + off[FIFO_PTR_BITS-1:0];
      res[k].last = pres[k] && ((pres >> (k + 1)) == '0);
      off         = off + (FIFO_PTR_BITS + 1)'(pres[k]);
    end
    push_n = off;
  end

  assign fifo_pop = (fifo_count_r != '0) && (!out_valid_r || !out_stall);
  assign head     = fifo_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      fifo_count_r <= '0;
    end else begin
      wr_ptr_r     <= wr_ptr_r + push_n[FIFO_PTR_BITS-1:0];
      rd_ptr_r     <= rd_ptr_r + FIFO_PTR_BITS'(fifo_pop);
      fifo_count_r <= fifo_count_r + push_n - (FIFO_PTR_BITS + 1)'(fifo_pop);
    end
    for (int k = 0; k < MAX_RUN; k++) begin
      if (pres[k]) begin
        fifo_mem_r[wr_idx[k]] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fifo_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fifo_pop) begin
      out_smoothed_r    <= mean_q(head.sum, head.cnt);
      out_row_r         <= head.row;
      out_col_r         <= head.col;
      out_last_in_run_r <= head.last;
      out_frame_end_r   <= head.fend;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_smoothed    = out_smoothed_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_in_run = out_last_in_run_r;
  assign out_frame_end   = out_frame_end_r;

  `NMS_ASSERT_NEXT(a_take_loads_stage, in_valid && !in_stall, p1_valid_r, "accepted beat did not reach the window stage")
  `NMS_ASSERT_NOW(a_queue_bounded, 1'b1, int'(fifo_count_r) <= FIFO_DEPTH, "result queue overflow")
  `NMS_ASSERT_NOW(a_frame_end_closes_run, out_valid_r && out_frame_end_r, out_last_in_run_r, "frame end not on the last result of its run")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the neighbour mean smoother, with a predictor and randomised beats.
module tb;
  import nms_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE2 = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE3 = CFG_INDEX_BITS'(3);
  localparam int RANDOM_TARGET = 300;
  localparam int BURST_WIDTH   = 32;
  localparam int DRAIN_PAUSE   = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_CAP    = 100;

  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_DIM, PIX_BRIGHT} pix_style_t;

  typedef struct {
    logic [SMOOTH_BITS-1:0] smoothed;
    logic [ROW_BITS-1:0]    row;
    logic [COL_BITS-1:0]    col;
    logic                   last;
    logic                   fend;
  } pixel_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [IN_BITS-1:0]        in_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [SMOOTH_BITS-1:0]    out_smoothed;
  logic [ROW_BITS-1:0]       out_row;
  logic [COL_BITS-1:0]       out_col;
  logic                      out_last_in_run;
  logic                      out_frame_end;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  neighbour_mean_smoother dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_smoothed    (out_smoothed),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_in_run (out_last_in_run),
    .out_frame_end   (out_frame_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bit [SAMPLE_BITS-1:0] upper_line [MAX_WIDTH];
  bit [SAMPLE_BITS-1:0] lower_line [MAX_WIDTH];
  bit [SAMPLE_BITS-1:0] win [3][3];
  int                   cur_row = 0;
  int                   cur_col = 0;
  int                   img_w = int'(RESET_WIDTH);
  int                   img_h = int'(RESET_HEIGHT);

  logic [IN_BITS-1:0] pending_samples [$];
  pixel_result_t      expected_pixels [$];
  int                 mismatch_count = 0;
  int                 random_items = 0;
  int                 idle_cycles = 0;
  int                 tx_wait = 0;
  int                 rx_wait = 0;
  bit                 tx_hold;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;

  bit [7:0] directed_frame [25] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd0,   8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd170, 8'd85,
    8'd0,   8'd1,   8'd128, 8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  function automatic pixel_result_t neighbour_mean(int pr, int pc, int cr, int cc);
    pixel_result_t res;
    int            sum;
    int            count;
    int            nr;
    int            nc;
    int            wr;
    int            wc;
    sum = 0;
    count = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = pr + dr;
        nc = pc + dc;
        wr = nr - cr + 2;
        wc = nc - cc + 2;
        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < img_h && nc < img_w &&
            wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
          sum += win[wr][wc];
          count++;
        end
      end
    end
    res.smoothed = (count != 0) ? SMOOTH_BITS'((sum * 256) / count) : '0;
    res.row      = ROW_BITS'(pr);
    res.col      = COL_BITS'(pc);
    res.last     = 1'b0;
    res.fend     = (pr == img_h - 1 && pc == img_w - 1);
    return res;
  endfunction

  task automatic smooth_sample(input logic [IN_BITS-1:0] pix);
    pixel_result_t        run [4];
    int                   n;
    bit [SAMPLE_BITS-1:0] up;
    bit [SAMPLE_BITS-1:0] lo;
    bit [SAMPLE_BITS-1:0] s;
    n = 0;
    s = pix[SAMPLE_BITS-1:0];
    up = upper_line[cur_col];
    lo = lower_line[cur_col];
    upper_line[cur_col] = lo;
    lower_line[cur_col] = s;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = s;
    if (cur_row >= 1) begin
      if (cur_col >= 1) begin
        run[n] = neighbour_mean(cur_row - 1, cur_col - 1, cur_row, cur_col);
        n++;
      end
      if (cur_col == img_w - 1) begin
        run[n] = neighbour_mean(cur_row - 1, cur_col, cur_row, cur_col);
        n++;
      end
    end
    if (cur_row == img_h - 1) begin
      if (cur_col >= 1) begin
        run[n] = neighbour_mean(cur_row, cur_col - 1, cur_row, cur_col);
        n++;
      end
      if (cur_col == img_w - 1) begin
        run[n] = neighbour_mean(cur_row, cur_col, cur_row, cur_col);
        n++;
      end
    end
    if (n > 0) run[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_pixels.push_back(run[k]);
    if (cur_col + 1 >= img_w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= img_h) ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  function automatic void apply_reg_write(logic [CFG_INDEX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] data);
    int v;
    if (idx == CFG_IMAGE_WIDTH) begin
      v = int'(data[WIDTH_BITS-1:0]);
      if (v >= MIN_SIZE && v <= MAX_WIDTH) img_w = v;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      v = int'(data[HEIGHT_BITS-1:0]);
      if (v >= MIN_SIZE && v <= MAX_HEIGHT) img_h = v;
    end else begin
      return;
    end
    cur_row = 0;
    cur_col = 0;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic queue_pixels(input int n, input pix_style_t style);
    logic [IN_BITS-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (style)
        PIX_EXTREME: v = $urandom_range(0, 1) ? '1 : '0;
        PIX_DIM:     v = IN_BITS'($urandom_range(0, 15));
        PIX_BRIGHT:  v = IN_BITS'($urandom_range(240, 255));
        default:     v = IN_BITS'($urandom_range(0, 255));
      endcase
      pending_samples.push_back(v);
    end
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic fail_field(input string name, input logic [SMOOTH_BITS-1:0] want,
                            input logic [SMOOTH_BITS-1:0] got);
    if (mismatch_count < REPORT_CAP)
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    mismatch_count++;
  endtask

  task automatic check_pixel();
    pixel_result_t want;
    if (expected_pixels.size() == 0) begin
      if (mismatch_count < REPORT_CAP)
        $error("result beat with nothing expected: row %0d col %0d", out_row, out_col);
      mismatch_count++;
      return;
    end
    want = expected_pixels.pop_front();
    if (out_smoothed !== want.smoothed) fail_field("smoothed", want.smoothed, out_smoothed);
    if (out_row !== want.row)
      fail_field("out_row", SMOOTH_BITS'(want.row), SMOOTH_BITS'(out_row));
    if (out_col !== want.col)
      fail_field("out_col", SMOOTH_BITS'(want.col), SMOOTH_BITS'(out_col));
    if (out_last_in_run !== want.last)
      fail_field("last_in_run", SMOOTH_BITS'(want.last), SMOOTH_BITS'(out_last_in_run));
    if (out_frame_end !== want.fend)
      fail_field("frame_end", SMOOTH_BITS'(want.fend), SMOOTH_BITS'(out_frame_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = draw_wait(tx_calm);
    end else begin
      tx_hold = in_valid;
      if (in_valid && !in_stall) begin
        smooth_sample(in_sample);
        tx_wait = draw_wait(tx_calm);
        tx_hold = 1'b0;
      end
      if (!tx_hold) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_sample <= pending_samples.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_pixel();
        rx_wait = draw_wait(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         w;
    int         h;
    int         n;
    int         k;
    pix_style_t style;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size of 5 by 5: corners, edges, interior, full-scale mean and the frame flush.
    for (int i = 0; i < 25; i++) pending_samples.push_back(directed_frame[i]);
    settle();

    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(MIN_SIZE));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(MIN_SIZE));
    for (int i = 0; i < 4; i++) pending_samples.push_back('1);
    queue_pixels(4, PIX_UNIFORM);
    settle();

    // Refused sizes and unused indexes leave the 2 by 2 size in place.
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(1));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(MAX_WIDTH + 1));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(1) << WIDTH_BITS);
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(0));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(1));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(MAX_HEIGHT + 1));
    write_reg(CFG_SPARE2, '1);
    write_reg(CFG_SPARE3, CFG_DATA_BITS'(3));
    queue_pixels(4, PIX_EXTREME);
    settle();

    // Upper data bits beyond the width register are dropped, giving a width of 3.
    write_reg(CFG_IMAGE_WIDTH, (CFG_DATA_BITS'(3) << WIDTH_BITS) | CFG_DATA_BITS'(3));
    queue_pixels(3, PIX_UNIFORM);
    settle();
    write_reg(CFG_SPARE3, CFG_DATA_BITS'(2));
    queue_pixels(3, PIX_UNIFORM);
    settle();

    tx_calm = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(BURST_WIDTH));
    queue_pixels(BURST_WIDTH * 2, PIX_UNIFORM);
    settle();

    tx_calm = 1'b0;
    rx_calm = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(MIN_SIZE));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(MAX_HEIGHT));
    queue_pixels(40, PIX_UNIFORM);
    settle();

    while (random_items < RANDOM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(9, 32);
        h = $urandom_range(2, 4);
      end else begin
        w = $urandom_range(2, 8);
        h = $urandom_range(2, 6);
      end
      write_reg(CFG_IMAGE_WIDTH,
                (CFG_DATA_BITS'($urandom_range(0, 3)) << WIDTH_BITS) | CFG_DATA_BITS'(w));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(MAX_WIDTH + 1, 2047)));
        1: write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 1) ?
                     CFG_DATA_BITS'($urandom_range(MAX_HEIGHT + 1, 8191)) :
                     CFG_DATA_BITS'($urandom_range(0, 1)));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0:       style = PIX_EXTREME;
        1:       style = PIX_DIM;
        2:       style = PIX_BRIGHT;
        default: style = PIX_UNIFORM;
      endcase
      n = $urandom_range(1, 2) * w * h;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w * h - 1);
      if ($urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, n - 1);
        queue_pixels(k, style);
        settle();
        write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3, CFG_DATA_BITS'($urandom));
        queue_pixels(n - k, style);
      end else begin
        queue_pixels(n, style);
      end
      random_items += n;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/nms_pkg.sv
sv/neighbour_mean_smoother.sv
verif/tb.sv
